[design/chip8_instruction_core_macros.svh]
// Assertion macros shared by the CHIP-8 core modules.
`ifndef CHIP8_INSTRUCTION_CORE_MACROS_SVH
`define CHIP8_INSTRUCTION_CORE_MACROS_SVH

// Checks the consequent in the same cycle as the antecedent.
`define C8_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define C8_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/c8_pkg.sv]
// Types, constants and helper functions of the CHIP-8 instruction core.
package c8_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int ADDR_W        = 12;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int FONT_BYTES    = 80;

    localparam logic [11:0] START_PC  = 12'h200;
    localparam logic [11:0] FONT_BASE = 12'h050;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_EXEC = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;
    localparam logic [1:0] REQ_ROW  = 2'd3;

    localparam logic [3:0] OPG_SYS   = 4'h0;
    localparam logic [3:0] OPG_JMP   = 4'h1;
    localparam logic [3:0] OPG_CALL  = 4'h2;
    localparam logic [3:0] OPG_SEQI  = 4'h3;
    localparam logic [3:0] OPG_SNEI  = 4'h4;
    localparam logic [3:0] OPG_SEQR  = 4'h5;
    localparam logic [3:0] OPG_LDI   = 4'h6;
    localparam logic [3:0] OPG_ADDI  = 4'h7;
    localparam logic [3:0] OPG_ALU   = 4'h8;
    localparam logic [3:0] OPG_SNER  = 4'h9;
    localparam logic [3:0] OPG_SETI  = 4'hA;
    localparam logic [3:0] OPG_JMPV  = 4'hB;
    localparam logic [3:0] OPG_RND   = 4'hC;
    localparam logic [3:0] OPG_DRAW  = 4'hD;
    localparam logic [3:0] OPG_KEY   = 4'hE;
    localparam logic [3:0] OPG_MISC  = 4'hF;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    localparam logic [3:0] AL_MOV  = 4'h0;
    localparam logic [3:0] AL_OR   = 4'h1;
    localparam logic [3:0] AL_AND  = 4'h2;
    localparam logic [3:0] AL_XOR  = 4'h3;
    localparam logic [3:0] AL_ADD  = 4'h4;
    localparam logic [3:0] AL_SUB  = 4'h5;
    localparam logic [3:0] AL_SHR  = 4'h6;
    localparam logic [3:0] AL_RSUB = 4'h7;
    localparam logic [3:0] AL_SHL  = 4'hE;

    localparam logic [7:0] NN_SKP   = 8'h9E;
    localparam logic [7:0] NN_SKNP  = 8'hA1;
    localparam logic [7:0] NN_GETDT = 8'h07;
    localparam logic [7:0] NN_WKEY  = 8'h0A;
    localparam logic [7:0] NN_SETDT = 8'h15;
    localparam logic [7:0] NN_SETST = 8'h18;
    localparam logic [7:0] NN_ADDI  = 8'h1E;
    localparam logic [7:0] NN_FONT  = 8'h29;
    localparam logic [7:0] NN_BCD   = 8'h33;
    localparam logic [7:0] NN_STORE = 8'h55;
    localparam logic [7:0] NN_LOAD  = 8'h65;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [3:0] {
        ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_RSUB, ALU_SHR, ALU_SHL
    } t_alu_op;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_FETCH_HI, S_FETCH_LO, S_READ_X, S_READ_Y, S_READ_V0, S_EXEC,
        S_WR_VF, S_CLS, S_DRAW_REQ, S_DRAW_ROW, S_BCD, S_ST_RD, S_ST_WR, S_LD_RD,
        S_LD_WR, S_ROW_RD, S_ROW_CAP, S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] load_address;
        logic [7:0]  load_byte;
        logic [15:0] keys_pressed;
        logic [7:0]  random_byte;
        logic [4:0]  row_select;
    } t_req;

    typedef struct packed {
        logic [11:0] pc_now;
        logic        sound_on;
        logic        waiting_key;
        logic [63:0] row_pixels;
    } t_rsp;

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
        logic       eq;
    } t_alu_out;

    // Reset contents of main memory: the hex font, zeros elsewhere.
    function automatic logic [7:0] font_byte(input logic [11:0] addr);
        logic [11:0] off;
        off = addr - FONT_BASE;
        if (addr >= FONT_BASE && off < 12'(FONT_BYTES)) begin
            return FONT_ROM[off[6:0]];
        end
        return 8'h00;
    endfunction

    // One decimal digit of an 8-bit value: 0 hundreds, 1 tens, 2 units.
    function automatic logic [3:0] bcd_digit(input logic [7:0] v, input logic [1:0] pos);
        logic [7:0] r;
        logic [3:0] h;
        logic [3:0] t;
        logic [7:0] u;
        if (v >= 8'd200) begin
            h = 4'd2;
            r = v - 8'd200;
        end else if (v >= 8'd100) begin
            h = 4'd1;
            r = v - 8'd100;
        end else begin
            h = 4'd0;
            r = v;
        end
        t = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (r >= 8'(k * 10)) begin
                t = 4'(k);
            end
        end
        u = r - {1'b0, t, 3'b000} - {3'b000, t, 1'b0};
        case (pos)
            2'd0:    return h;
            2'd1:    return t;
            default: return u[3:0];
        endcase
    endfunction

endpackage

[design/c8_ifs.sv]
// Valid/ready channel interfaces for requests and responses of the core.
interface c8_req_if;
    logic          valid;
    logic          ready;
    c8_pkg::t_req  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface c8_rsp_if;
    logic          valid;
    logic          ready;
    c8_pkg::t_rsp  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[design/c8_alu.sv]
// Shared 8-bit arithmetic, logic, shift and compare unit of the core.
module c8_alu (
    input  c8_pkg::t_alu_op  i_op,
    input  logic [7:0]       i_a,
    input  logic [7:0]       i_b,
    output c8_pkg::t_alu_out o_out
);
    import c8_pkg::*;

    logic [8:0] sum;

    assign sum = {1'b0, i_a} + {1'b0, i_b};

    always_comb begin
        o_out.eq   = (i_a == i_b);
        o_out.flag = 1'b0;
        o_out.res  = i_b;
        unique case (i_op)
            ALU_MOV: o_out.res = i_b;
            ALU_OR:  o_out.res = i_a | i_b;
            ALU_AND: o_out.res = i_a & i_b;
            ALU_XOR: o_out.res = i_a ^ i_b;
            ALU_ADD: begin
                o_out.res  = sum[7:0];
                o_out.flag = sum[8];
            end
            ALU_SUB: begin
                o_out.res  = i_a - i_b;
                o_out.flag = (i_a >= i_b);
            end
            ALU_RSUB: begin
                o_out.res  = i_b - i_a;
                o_out.flag = (i_b >= i_a);
            end
            ALU_SHR: begin
                o_out.res  = {1'b0, i_b[7:1]};
                o_out.flag = i_b[0];
            end
            ALU_SHL: begin
                o_out.res  = {i_b[6:0], 1'b0};
                o_out.flag = i_b[7];
            end
            default: o_out.res = i_b;
        endcase
    end
endmodule

[design/c8_mem.sv]
// Main byte memory with a registered read port and a font-loading pass after reset.
`include "chip8_instruction_core_macros.svh"
module c8_mem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [11:0] i_waddr,
    input  logic [7:0]  i_wdata,
    input  logic [11:0] i_raddr,
    output logic [7:0]  o_rdata,
    output logic        o_busy
);
    import c8_pkg::*;

    logic [7:0]  r_mem [MEM_BYTES];
    logic [7:0]  r_rdata;
    logic [11:0] r_clr;
    logic        r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_clr <= r_clr + 12'd1;
            if (r_clr == 12'(MEM_BYTES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr] <= font_byte(r_clr);
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

    `C8_ASSERT_NOW(a_no_write_in_clear, r_busy, !i_we, "write during memory clear")
    `C8_ASSERT_NEXT(a_clear_once, !r_busy, !r_busy, "memory clear restarted")
    `C8_ASSERT_NOW(a_clear_full, $fell(r_busy), $past(r_clr) == 12'(MEM_BYTES - 1),
        "memory clear ended early")
endmodule

[design/chip8_instruction_core.sv]
// CHIP-8 instruction core: sequencer, register file, stack, timers and display store.
// Load and tick go from idle to the done state; a row read adds row read and capture states.
// Execute fetches the opcode and reads VX, VY, V0; flag-setting 8XY ops and FX1E add a VF write;
// 00E0 walks each display row, DXYN each drawn row, FX33 three digits, FX55/FX65 each register.
// One item is handled at a time; the next request transfers with its response at the earliest.
// Reset is synchronous; afterwards all 4096 bytes of main memory are swept, loading the
// font while the display is cleared, and no request is accepted until that ends.
`include "chip8_instruction_core_macros.svh"
module chip8_instruction_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    c8_req_if.sink   i_req,
    c8_rsp_if.source o_rsp
);
    import c8_pkg::*;

    localparam int LVL_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    t_state r_state;
    t_state n_state;

    logic [15:0] r_op;
    logic [7:0]  r_a;
    logic [7:0]  r_b;
    logic [11:0] r_pc;
    logic [15:0] r_index;
    logic [LVL_W-1:0] r_lvl;
    logic [11:0] r_stack [STACK_DEPTH];
    logic [7:0]  r_delay;
    logic [7:0]  r_sound;
    logic [4:0]  r_cnt;
    logic        r_vf;
    logic        r_hit;
    logic [15:0] r_keys;
    logic [7:0]  r_rnd;
    logic [4:0]  r_row_sel;
    logic        r_out_valid;
    logic        r_wait;
    logic [63:0] r_row;

    logic [7:0]  r_rf [16];
    logic [7:0]  r_rf_rdata;
    logic [63:0] r_frame [SCREEN_HEIGHT];
    logic [63:0] r_fr_rdata;

    logic        accept;
    logic        mem_we;
    logic [11:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic [11:0] mem_raddr;
    logic [7:0]  mem_rdata;
    logic        mem_busy;
    logic        rf_we;
    logic [3:0]  rf_waddr;
    logic [7:0]  rf_wdata;
    logic [3:0]  rf_raddr;
    logic        fr_we;
    logic [4:0]  fr_waddr;
    logic [63:0] fr_wdata;
    logic [4:0]  fr_raddr;
    t_alu_op     alu_op;
    logic [7:0]  alu_a;
    logic [7:0]  alu_b;
    t_alu_out    alu_out;

    logic [3:0]  opg;
    logic [3:0]  op_x;
    logic [7:0]  op_nn;
    logic [11:0] idx_off;
    logic [5:0]  draw_sum;
    logic [4:0]  draw_row;
    logic        draw_go;
    logic [63:0] draw_mask;
    logic        key_any;
    logic [3:0]  key_idx;
    logic        key_hit;
    logic        al_known;
    logic        al_flag;
    logic [15:0] idx_sum;
    logic [LVL_W-1:0] lvl_inc;
    logic [LVL_W-1:0] lvl_dec;

    assign opg      = r_op[15:12];
    assign op_x     = r_op[11:8];
    assign op_nn    = r_op[7:0];
    assign idx_off  = r_index[11:0] + {7'b0, r_cnt};
    assign draw_sum = {1'b0, r_b[4:0]} + {1'b0, r_cnt};
    assign draw_row = draw_sum[4:0];
    assign draw_go  = (r_cnt < {1'b0, r_op[3:0]}) && !draw_sum[5];
    assign draw_mask = {mem_rdata, 56'b0} >> r_a[5:0];
    assign key_hit  = r_keys[r_a[3:0]];
    assign idx_sum  = r_index + {8'b0, r_a};
    assign lvl_inc  = (r_lvl == LVL_W'(STACK_DEPTH - 1)) ? '0 : r_lvl + 1'b1;
    assign lvl_dec  = (r_lvl == '0) ? LVL_W'(STACK_DEPTH - 1) : r_lvl - 1'b1;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE) && !mem_busy && (!r_out_valid || o_rsp.ready);

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.data.pc_now      = r_pc;
    assign o_rsp.data.sound_on    = (r_sound != 8'd0);
    assign o_rsp.data.waiting_key = r_wait;
    assign o_rsp.data.row_pixels  = r_row;

    always_comb begin
        key_any = 1'b0;
        key_idx = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) begin
                key_any = 1'b1;
                key_idx = 4'(k);
            end
        end
    end

    always_comb begin
        case (r_op[3:0])
            AL_MOV, AL_OR, AL_AND, AL_XOR: begin
                al_known = 1'b1;
                al_flag  = 1'b0;
            end
            AL_ADD, AL_SUB, AL_SHR, AL_RSUB, AL_SHL: begin
                al_known = 1'b1;
                al_flag  = 1'b1;
            end
            default: begin
                al_known = 1'b0;
                al_flag  = 1'b0;
            end
        endcase
    end

    c8_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_out (alu_out)
    );

    c8_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:     if (r_cnt == 5'(SCREEN_HEIGHT - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.data.req_type)
                        REQ_EXEC: n_state = S_FETCH_HI;
                        REQ_ROW:  n_state = S_ROW_RD;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_FETCH_HI: n_state = S_FETCH_LO;
            S_FETCH_LO: n_state = S_READ_X;
            S_READ_X:   n_state = S_READ_Y;
            S_READ_Y:   n_state = S_READ_V0;
            S_READ_V0:  n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_DONE;
                case (opg)
                    OPG_SYS:  if (r_op == OP_CLS) n_state = S_CLS;
                    OPG_ALU:  if (al_flag) n_state = S_WR_VF;
                    OPG_DRAW: n_state = S_DRAW_REQ;
                    OPG_MISC: begin
                        case (op_nn)
                            NN_ADDI:  n_state = S_WR_VF;
                            NN_BCD:   n_state = S_BCD;
                            NN_STORE: n_state = S_ST_RD;
                            NN_LOAD:  n_state = S_LD_RD;
                            default:  n_state = S_DONE;
                        endcase
                    end
                    default:  n_state = S_DONE;
                endcase
            end
            S_WR_VF:    n_state = S_DONE;
            S_CLS:      if (r_cnt == 5'(SCREEN_HEIGHT - 1)) n_state = S_DONE;
            S_DRAW_REQ: n_state = draw_go ? S_DRAW_ROW : S_WR_VF;
            S_DRAW_ROW: n_state = S_DRAW_REQ;
            S_BCD:      if (r_cnt == 5'd2) n_state = S_DONE;
            S_ST_RD:    n_state = S_ST_WR;
            S_ST_WR:    n_state = (r_cnt[3:0] == op_x) ? S_DONE : S_ST_RD;
            S_LD_RD:    n_state = S_LD_WR;
            S_LD_WR:    n_state = (r_cnt[3:0] == op_x) ? S_DONE : S_LD_RD;
            S_ROW_RD:   n_state = S_ROW_CAP;
            S_ROW_CAP:  n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_off;
        mem_wdata = 8'd0;
        mem_raddr = idx_off;
        rf_we     = 1'b0;
        rf_waddr  = op_x;
        rf_wdata  = alu_out.res;
        rf_raddr  = op_x;
        fr_we     = 1'b0;
        fr_waddr  = draw_row;
        fr_wdata  = '0;
        fr_raddr  = draw_row;
        alu_op    = ALU_MOV;
        alu_a     = r_a;
        alu_b     = r_b;
        unique case (r_state)
            S_INIT, S_CLS: begin
                fr_we    = 1'b1;
                fr_waddr = r_cnt;
            end
            S_IDLE: begin
                if (accept && i_req.data.req_type == REQ_LOAD) begin
                    mem_we    = 1'b1;
                    mem_waddr = i_req.data.load_address;
                    mem_wdata = i_req.data.load_byte;
                end
            end
            S_FETCH_HI: mem_raddr = r_pc;
            S_FETCH_LO: mem_raddr = r_pc + 12'd1;
            S_READ_Y:   rf_raddr  = r_op[7:4];
            S_READ_V0:  rf_raddr  = 4'd0;
            S_EXEC: begin
                case (opg)
                    OPG_SEQI, OPG_SNEI: alu_b = op_nn;
                    OPG_LDI: begin
                        alu_b = op_nn;
                        rf_we = 1'b1;
                    end
                    OPG_ADDI: begin
                        alu_op = ALU_ADD;
                        alu_b  = op_nn;
                        rf_we  = 1'b1;
                    end
                    OPG_RND: begin
                        alu_op = ALU_AND;
                        alu_a  = r_rnd;
                        alu_b  = op_nn;
                        rf_we  = 1'b1;
                    end
                    OPG_ALU: begin
                        rf_we = al_known;
                        case (r_op[3:0])
                            AL_OR:   alu_op = ALU_OR;
                            AL_AND:  alu_op = ALU_AND;
                            AL_XOR:  alu_op = ALU_XOR;
                            AL_ADD:  alu_op = ALU_ADD;
                            AL_SUB:  alu_op = ALU_SUB;
                            AL_SHR:  alu_op = ALU_SHR;
                            AL_RSUB: alu_op = ALU_RSUB;
                            AL_SHL:  alu_op = ALU_SHL;
                            default: alu_op = ALU_MOV;
                        endcase
                    end
                    OPG_MISC: begin
                        if (op_nn == NN_GETDT) begin
                            rf_we    = 1'b1;
                            rf_wdata = r_delay;
                        end else if (op_nn == NN_WKEY) begin
                            rf_we    = key_any;
                            rf_wdata = {4'd0, key_idx};
                        end
                    end
                    default: alu_op = ALU_MOV;
                endcase
            end
            S_WR_VF: begin
                rf_we    = 1'b1;
                rf_waddr = 4'hF;
                rf_wdata = {7'd0, r_vf};
            end
            S_DRAW_ROW: begin
                fr_we    = 1'b1;
                fr_wdata = r_fr_rdata ^ draw_mask;
            end
            S_BCD: begin
                mem_we    = 1'b1;
                mem_wdata = {4'd0, bcd_digit(r_a, r_cnt[1:0])};
            end
            S_ST_RD:  rf_raddr = r_cnt[3:0];
            S_ST_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rf_rdata;
            end
            S_LD_WR: begin
                rf_we    = 1'b1;
                rf_waddr = r_cnt[3:0];
                rf_wdata = mem_rdata;
            end
            S_ROW_RD: fr_raddr = r_row_sel;
            default:  rf_raddr = op_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) begin
                r_rf[k] <= 8'd0;
            end
        end else if (rf_we) begin
            r_rf[rf_waddr] <= rf_wdata;
        end
        r_rf_rdata <= r_rf[rf_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            r_frame[fr_waddr] <= fr_wdata;
        end
        r_fr_rdata <= r_frame[fr_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= START_PC;
            r_index     <= 16'd0;
            r_lvl       <= '0;
            r_delay     <= 8'd0;
            r_sound     <= 8'd0;
            r_cnt       <= 5'd0;
            r_out_valid <= 1'b0;
            r_wait      <= 1'b0;
            r_row       <= 64'd0;
            for (int k = 0; k < STACK_DEPTH; k++) begin
                r_stack[k] <= 12'd0;
            end
        end else begin
            if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT, S_CLS: r_cnt <= r_cnt + 5'd1;
                S_IDLE: begin
                    if (accept) begin
                        r_wait    <= 1'b0;
                        r_row     <= 64'd0;
                        r_keys    <= i_req.data.keys_pressed;
                        r_rnd     <= i_req.data.random_byte;
                        r_row_sel <= i_req.data.row_select;
                        if (i_req.data.req_type == REQ_TICK) begin
                            if (r_delay != 8'd0) r_delay <= r_delay - 8'd1;
                            if (r_sound != 8'd0) r_sound <= r_sound - 8'd1;
                        end
                    end
                end
                S_FETCH_LO: r_op[15:8] <= mem_rdata;
                S_READ_X: begin
                    r_op[7:0] <= mem_rdata;
                    r_pc      <= r_pc + 12'd2;
                end
                S_READ_Y:  r_a <= r_rf_rdata;
                S_READ_V0: r_b <= r_rf_rdata;
                S_EXEC: begin
                    r_cnt <= 5'd0;
                    r_hit <= 1'b0;
                    case (opg)
                        OPG_SYS: begin
                            if (r_op == OP_RET) begin
                                r_pc  <= r_stack[r_lvl];
                                r_lvl <= lvl_dec;
                            end
                        end
                        OPG_JMP: r_pc <= r_op[11:0];
                        OPG_CALL: begin
                            r_lvl            <= lvl_inc;
                            r_stack[lvl_inc] <= r_pc;
                            r_pc             <= r_op[11:0];
                        end
                        OPG_SEQI, OPG_SEQR: if (alu_out.eq) r_pc <= r_pc + 12'd2;
                        OPG_SNEI, OPG_SNER: if (!alu_out.eq) r_pc <= r_pc + 12'd2;
                        OPG_SETI: r_index <= {4'd0, r_op[11:0]};
                        OPG_JMPV: r_pc <= r_op[11:0] + {4'd0, r_rf_rdata};
                        OPG_KEY: begin
                            if ((op_nn == NN_SKP && key_hit) || (op_nn == NN_SKNP && !key_hit)) begin
                                r_pc <= r_pc + 12'd2;
                            end
                        end
                        OPG_MISC: begin
                            case (op_nn)
                                NN_WKEY: begin
                                    if (!key_any) begin
                                        r_pc   <= r_pc - 12'd2;
                                        r_wait <= 1'b1;
                                    end
                                end
                                NN_SETDT: r_delay <= r_a;
                                NN_SETST: r_sound <= r_a;
                                NN_ADDI: begin
                                    r_index <= idx_sum;
                                    r_vf    <= (idx_sum[15:12] != 4'd0);
                                end
                                NN_FONT: r_index <= {4'd0, FONT_BASE}
                                    + {6'd0, r_a, 2'b00} + {8'd0, r_a};
                                default: r_vf <= alu_out.flag;
                            endcase
                        end
                        default: r_vf <= alu_out.flag;
                    endcase
                end
                S_DRAW_REQ: if (!draw_go) r_vf <= r_hit;
                S_DRAW_ROW: begin
                    r_hit <= r_hit | ((r_fr_rdata & draw_mask) != 64'd0);
                    r_cnt <= r_cnt + 5'd1;
                end
                S_BCD:     r_cnt <= r_cnt + 5'd1;
                S_ST_WR:   r_cnt <= r_cnt + 5'd1;
                S_LD_WR:   r_cnt <= r_cnt + 5'd1;
                S_ROW_CAP: r_row <= r_fr_rdata;
                S_DONE:    r_out_valid <= 1'b1;
                default:   r_cnt <= r_cnt;
            endcase
        end
    end

    `C8_ASSERT_NOW(a_ready_idle, i_req.ready, r_state == S_IDLE && !mem_busy,
        "request ready outside idle")
    `C8_ASSERT_NOW(a_rsp_from_done, $rose(r_out_valid), $past(r_state == S_DONE),
        "response raised outside done")
    `C8_ASSERT_NEXT(a_exec_moves_on, r_state == S_EXEC,
        r_state != S_EXEC && r_state != S_IDLE, "execute did not advance")
endmodule
